// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the angle correction polynomial core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet while arst_n is low.
`define ACP_ASSERT_IMP(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and quiet while arst_n is low.
`define ACP_ASSERT_NXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== rtl/acp_pkg.sv =====
// Constants, types and helper functions of the angle correction polynomial core.
package acp_pkg;

	// Polynomial orders and sample width.
	localparam int ORDER_ANGLE   = 3;
	localparam int ORDER_POS     = 3;
	localparam int SAMPLE_WIDTH  = 16;

	// Port field widths.
	localparam int PORT_SAMPLE_W = 16;
	localparam int COEF_W        = 64;
	localparam int COEF_IDX_W    = 5;
	localparam int VALUE_W       = 64;

	// Transaction kinds on the input channel.
	localparam logic KIND_EVAL   = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	// Coefficient table layout: the full a/x grid, then two groups of four
	// cross terms for y and y^2.
	localparam int CROSS_BASE    = (ORDER_ANGLE + 1) * (ORDER_POS + 1);
	localparam int TABLE_DEPTH   = CROSS_BASE + 8;
	localparam int ADDR_W        = $clog2(TABLE_DEPTH);

	// Coefficients are Q8.56, results Q31.32.
	localparam int COEF_FRAC     = 56;
	localparam int VALUE_FRAC    = 32;
	localparam int FRAC_DROP     = COEF_FRAC - VALUE_FRAC;

	// Exact accumulator: coefficient bits, the largest monomial degree times the
	// sample magnitude bits, and headroom for the number of terms plus sign.
	localparam int DEG_MAX       = (ORDER_ANGLE + ORDER_POS > 4) ?
	                               (ORDER_ANGLE + ORDER_POS) : 4;
	localparam int ACC_NEED      = COEF_W + (SAMPLE_WIDTH - 1) * DEG_MAX + 7;
	localparam int LIMB_W        = 32;
	localparam int NUM_LIMBS     = (ACC_NEED + LIMB_W - 1) / LIMB_W;
	localparam int ACC_W         = NUM_LIMBS * LIMB_W;
	localparam int LIMB_IDX_W    = $clog2(NUM_LIMBS);

	// Limb multiply-add: unsigned limb times signed sample, plus addend limb
	// and signed carry.
	localparam int PROD_W        = LIMB_W + 1 + SAMPLE_WIDTH;
	localparam int SUM_W         = LIMB_W + SAMPLE_WIDTH + 2;
	localparam int CARRY_W       = SUM_W - LIMB_W;

	// Datapath operations issued by the sequencer.
	typedef logic [2:0] acp_op_t;
	localparam acp_op_t OP_NOP   = 3'd0;
	localparam acp_op_t OP_LOAD  = 3'd1;  // R0 takes the fetched coefficient
	localparam acp_op_t OP_MAC0  = 3'd2;  // R0 = R0 * x + coefficient, one limb
	localparam acp_op_t OP_MAC1  = 3'd3;  // R1 = R1 * a + R0, one limb
	localparam acp_op_t OP_MAC2  = 3'd4;  // R2 = R2 * y + R1, one limb
	localparam acp_op_t OP_COPY1 = 3'd5;  // R1 takes R0
	localparam acp_op_t OP_COPY2 = 3'd6;  // R2 takes R1
	localparam acp_op_t OP_ROUND = 3'd7;  // round and saturate R2 into the output

	typedef struct packed {
		acp_op_t                 op;
		logic [LIMB_IDX_W-1:0]   limb;
		logic                    capture;
	} acp_ctrl_t;

	// Takes the low SAMPLE_WIDTH bits of a port sample as two's complement.
	function automatic logic signed [SAMPLE_WIDTH-1:0] take_sample(
		input logic [PORT_SAMPLE_W-1:0] raw);
		logic [SAMPLE_WIDTH+PORT_SAMPLE_W-1:0] ext;
		ext = {{SAMPLE_WIDTH{1'b0}}, raw};
		return ext[SAMPLE_WIDTH-1:0];
	endfunction

endpackage

// ===== rtl/acp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module acp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/acp_datapath.sv =====
// Shared limb multiply-add unit with the three Horner registers and the final rounding.
module acp_datapath (
	input  logic                                clk,
	input  acp_pkg::acp_ctrl_t                  ctrl,
	input  logic [acp_pkg::COEF_W-1:0]          coef,
	input  logic signed [acp_pkg::PORT_SAMPLE_W-1:0] pos_x,
	input  logic signed [acp_pkg::PORT_SAMPLE_W-1:0] angle_a,
	input  logic signed [acp_pkg::PORT_SAMPLE_W-1:0] pos_y,
	output logic signed [acp_pkg::VALUE_W-1:0]  res_value,
	output logic                                res_sat
);
	import acp_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] x_q, a_q, y_q;
	logic [ACC_W-1:0]               r0_q, r1_q, r2_q;
	logic signed [CARRY_W-1:0]      carry_q;

	logic [ACC_W-1:0]               coef_ext;
	logic [ACC_W-1:0]               src;
	logic [ACC_W-1:0]               addend;
	logic signed [SAMPLE_WIDTH-1:0] mult;
	logic [LIMB_W-1:0]              src_limb;
	logic [LIMB_W-1:0]              add_limb;
	logic signed [CARRY_W-1:0]      carry_in;
	logic signed [PROD_W-1:0]       prod;
	logic signed [SUM_W-1:0]        sum;
	logic [LIMB_W-1:0]              new_limb;

	logic [ACC_W-1:0]               rounded;
	logic [ACC_W-FRAC_DROP-VALUE_W:0] top_bits;
	logic                           fits;

	assign coef_ext = ACC_W'($signed(coef));

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (ctrl.op)
			OP_MAC1: begin
				src    = r1_q;
				mult   = a_q;
				addend = r0_q;
			end
			OP_MAC2: begin
				src    = r2_q;
				mult   = y_q;
				addend = r1_q;
			end
			default: begin
				src    = r0_q;
				mult   = x_q;
				addend = coef_ext;
			end
		endcase
	end

	assign src_limb = src[int'(ctrl.limb) * LIMB_W +: LIMB_W];
	assign add_limb = addend[int'(ctrl.limb) * LIMB_W +: LIMB_W];
	assign carry_in = (ctrl.limb == '0) ? '0 : carry_q;
	assign prod     = $signed({1'b0, src_limb}) * mult;
	assign sum      = SUM_W'(prod) + SUM_W'($signed({1'b0, add_limb})) + SUM_W'(carry_in);
	assign new_limb = sum[LIMB_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			x_q <= take_sample(pos_x);
			a_q <= take_sample(angle_a);
			y_q <= take_sample(pos_y);
		end
		unique case (ctrl.op)
			OP_LOAD:  r0_q <= coef_ext;
			OP_COPY1: r1_q <= r0_q;
			OP_COPY2: r2_q <= r1_q;
			OP_MAC0: begin
				r0_q[int'(ctrl.limb) * LIMB_W +: LIMB_W] <= new_limb;
				carry_q <= sum[SUM_W-1:LIMB_W];
			end
			OP_MAC1: begin
				r1_q[int'(ctrl.limb) * LIMB_W +: LIMB_W] <= new_limb;
				carry_q <= sum[SUM_W-1:LIMB_W];
			end
			OP_MAC2: begin
				r2_q[int'(ctrl.limb) * LIMB_W +: LIMB_W] <= new_limb;
				carry_q <= sum[SUM_W-1:LIMB_W];
			end
			default: begin
			end
		endcase
	end

	// Round half up to Q.32, then clip to the signed 64-bit range.
	assign rounded  = r2_q + (ACC_W'(1) << (FRAC_DROP - 1));
	assign top_bits = rounded[ACC_W-1:FRAC_DROP+VALUE_W-1];
	assign fits     = (&top_bits) || !(|top_bits);

	always_comb begin
		if (fits) begin
			res_value = rounded[FRAC_DROP+VALUE_W-1:FRAC_DROP];
		end else if (rounded[ACC_W-1]) begin
			res_value = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			res_value = {1'b0, {(VALUE_W-1){1'b1}}};
		end
	end

	assign res_sat = !fits;

endmodule

// ===== rtl/acp_seq.sv =====
// Sequencer that walks the nested Horner evaluation over the shared multiply-add unit.
`include "assert_macros.svh"

module acp_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        kind,
	input  logic                        out_free,
	output logic                        in_ready,
	output logic                        ram_re,
	output logic [acp_pkg::ADDR_W-1:0]  ram_raddr,
	output acp_pkg::acp_ctrl_t          ctrl
);
	import acp_pkg::*;

	localparam int IA_W = $clog2(ORDER_ANGLE + 1);
	localparam int IX_W = $clog2(ORDER_POS + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FETCH = 4'd1;
	localparam logic [3:0] ST_LOAD  = 4'd2;
	localparam logic [3:0] ST_XMAC  = 4'd3;
	localparam logic [3:0] ST_ACOPY = 4'd4;
	localparam logic [3:0] ST_AMAC  = 4'd5;
	localparam logic [3:0] ST_YCOPY = 4'd6;
	localparam logic [3:0] ST_YMAC  = 4'd7;
	localparam logic [3:0] ST_ROUND = 4'd8;

	// Rows in y: two cross groups, then the full a/x grid.
	localparam logic [1:0] KY_TOP = 2'd2;

	logic [3:0]            state_q, state_d;
	logic [1:0]            ky_q, ky_d, ky_dn;
	logic [IA_W-1:0]       i_q, i_d;
	logic [IX_W-1:0]       j_q, j_d;
	logic [LIMB_IDX_W-1:0] limb_q, limb_d;
	logic                  last_limb;

	function automatic logic [IA_W-1:0] a_order(input logic [1:0] ky);
		return (ky == 2'd0) ? IA_W'(ORDER_ANGLE) : IA_W'(1);
	endfunction

	function automatic logic [IX_W-1:0] x_order(input logic [1:0] ky);
		return (ky == 2'd0) ? IX_W'(ORDER_POS) : IX_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] coef_addr(input logic [1:0] ky,
		input logic [IA_W-1:0] i, input logic [IX_W-1:0] j);
		int idx;
		if (ky == 2'd0) begin
			idx = (ORDER_POS + 1) * int'(i) + int'(j);
		end else begin
			idx = CROSS_BASE + 4 * (int'(ky) - 1) + 2 * int'(i) + int'(j);
		end
		return ADDR_W'(idx);
	endfunction

	assign ky_dn     = ky_q - 2'd1;
	assign last_limb = (limb_q == LIMB_IDX_W'(NUM_LIMBS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign ram_raddr = coef_addr(ky_q, i_q, j_q);

	always_comb begin
		state_d      = state_q;
		ky_d         = ky_q;
		i_d          = i_q;
		j_d          = j_q;
		limb_d       = limb_q;
		ram_re       = 1'b0;
		ctrl.op      = OP_NOP;
		ctrl.limb    = limb_q;
		ctrl.capture = 1'b0;
		unique case (state_q) inside
			ST_IDLE: begin
				if (in_valid && kind == KIND_EVAL) begin
					ctrl.capture = 1'b1;
					ky_d         = KY_TOP;
					i_d          = a_order(KY_TOP);
					j_d          = x_order(KY_TOP);
					state_d      = ST_FETCH;
				end
			end
			ST_FETCH: begin
				ram_re  = 1'b1;
				state_d = (j_q == x_order(ky_q)) ? ST_LOAD : ST_XMAC;
			end
			ST_LOAD: begin
				ctrl.op = OP_LOAD;
				j_d     = j_q - IX_W'(1);
				state_d = ST_FETCH;
			end
			ST_XMAC: begin
				ctrl.op = OP_MAC0;
				if (last_limb) begin
					limb_d = '0;
					if (j_q == '0) begin
						state_d = (i_q == a_order(ky_q)) ? ST_ACOPY : ST_AMAC;
					end else begin
						j_d     = j_q - IX_W'(1);
						state_d = ST_FETCH;
					end
				end else begin
					limb_d = limb_q + LIMB_IDX_W'(1);
				end
			end
			ST_ACOPY, ST_AMAC: begin
				ctrl.op = (state_q == ST_ACOPY) ? OP_COPY1 : OP_MAC1;
				if (state_q == ST_ACOPY || last_limb) begin
					limb_d = '0;
					if (i_q == '0) begin
						state_d = (ky_q == KY_TOP) ? ST_YCOPY : ST_YMAC;
					end else begin
						i_d     = i_q - IA_W'(1);
						j_d     = x_order(ky_q);
						state_d = ST_FETCH;
					end
				end else begin
					limb_d = limb_q + LIMB_IDX_W'(1);
				end
			end
			ST_YCOPY, ST_YMAC: begin
				ctrl.op = (state_q == ST_YCOPY) ? OP_COPY2 : OP_MAC2;
				if (state_q == ST_YCOPY || last_limb) begin
					limb_d = '0;
					if (ky_q == 2'd0) begin
						state_d = ST_ROUND;
					end else begin
						ky_d    = ky_dn;
						i_d     = a_order(ky_dn);
						j_d     = x_order(ky_dn);
						state_d = ST_FETCH;
					end
				end else begin
					limb_d = limb_q + LIMB_IDX_W'(1);
				end
			end
			ST_ROUND: begin
				if (out_free) begin
					ctrl.op = OP_ROUND;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ky_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			limb_q  <= '0;
		end else begin
			state_q <= state_d;
			ky_q    <= ky_d;
			i_q     <= i_d;
			j_q     <= j_d;
			limb_q  <= limb_d;
		end
	end

	`ACP_ASSERT_IMP(a_limb_idle, (state_q != ST_XMAC && state_q != ST_AMAC && state_q != ST_YMAC), (limb_q == '0), "limb counter left nonzero outside a multiply pass")
	`ACP_ASSERT_NXT(a_eval_starts, (in_valid && in_ready && kind == KIND_EVAL), (state_q == ST_FETCH), "evaluate transaction did not start a coefficient fetch")
	`ACP_ASSERT_NXT(a_fetch_used, (state_q == ST_FETCH), (state_q == ST_LOAD || state_q == ST_XMAC), "fetched coefficient not consumed in the next cycle")

endmodule

// ===== rtl/angle_correction_polynomial_core.sv =====
// Top level of the correction core: coefficient RAM, sequencer, datapath, output register.
//
// Usage. Input transactions carry either a coefficient load (kind = 1) or an
// evaluation request (kind = 0). A load writes coef_value into slot coef_index
// of the 24-entry Q8.56 coefficient table in the cycle it is accepted and gives
// no result; an index past the table is dropped. A slot must be loaded before
// any evaluation reads it. An evaluation captures pos_x, angle_a and pos_y and
// runs a nested Horner scheme (x inside a inside y) over one shared limb
// multiplier, a 33 x 16 bit signed product plus addend and carry, stepping
// through a 192-bit exact accumulator one 32-bit limb per cycle.
// With the default orders an evaluation takes 23 multiply passes over the six
// limbs, 24 coefficient reads from the RAM, eight row loads, four copies and
// one rounding step. in_ready is low while an evaluation runs, so the core
// takes no new transaction until the evaluation is through; loads are taken
// back to back whenever the core is idle.
// The result is a saturated Q31.32 value with a saturated flag, held in an
// output register. If the receiver stalls, the core still accepts the next
// transaction and runs it; it waits at the rounding step until the register
// is free. Reset clears the control state and the output valid; the
// coefficient table keeps no reset value and must be loaded again.
`include "assert_macros.svh"

module angle_correction_polynomial_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     kind,
	input  logic [acp_pkg::COEF_IDX_W-1:0]           coef_index,
	input  logic signed [acp_pkg::COEF_W-1:0]        coef_value,
	input  logic signed [acp_pkg::PORT_SAMPLE_W-1:0] pos_x,
	input  logic signed [acp_pkg::PORT_SAMPLE_W-1:0] angle_a,
	input  logic signed [acp_pkg::PORT_SAMPLE_W-1:0] pos_y,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [acp_pkg::VALUE_W-1:0]       value,
	output logic                                     saturated
);
	import acp_pkg::*;

	acp_ctrl_t                 ctrl;
	logic                      ram_we;
	logic                      ram_re;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [COEF_W-1:0]         ram_rdata;
	logic                      out_free;
	logic signed [VALUE_W-1:0] res_value;
	logic                      res_sat;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      saturated_q;

	// The output register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || out_ready;

	// Coefficient loads go straight into the table; out-of-range slots are ignored.
	assign ram_we = in_valid && in_ready && (kind == KIND_LOAD) &&
	                (32'(coef_index) < TABLE_DEPTH);

	acp_ram #(
		.WIDTH (COEF_W),
		.DEPTH (TABLE_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(coef_index)),
		.wdata (coef_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	acp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ctrl      (ctrl)
	);

	acp_datapath u_datapath (
		.clk       (clk),
		.ctrl      (ctrl),
		.coef      (ram_rdata),
		.pos_x     (pos_x),
		.angle_a   (angle_a),
		.pos_y     (pos_y),
		.res_value (res_value),
		.res_sat   (res_sat)
	);

	// Output register: loaded by the rounding step, emptied when the
	// transaction is taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_ROUND) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_ROUND) begin
			value_q     <= res_value;
			saturated_q <= res_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign saturated = saturated_q;

	`ACP_ASSERT_IMP(a_round_needs_room, (ctrl.op == OP_ROUND), (!out_valid_q || out_ready), "result written over an output transaction still waiting")

endmodule

// ===== sim/angle_correction_polynomial_core_test.sv =====
// Self-checking testbench for the angle correction polynomial core.
`timescale 1ns / 1ps

// The bench drives coefficient loads and evaluation requests through the input
// channel and checks every result that leaves the output channel against a
// predictor kept inside the bench. The predictor mirrors the coefficient table
// and forms the polynomial with wide signed arithmetic, so the sum is exact
// before the single rounding step and the Q31.32 saturation.
//
// The run goes through these steps in order:
//   - fill every coefficient slot, so that no evaluation ever reads a slot
//     that was never written,
//   - directed corners: loads past the end of the table, rounding ties in
//     both directions, the extreme coefficients, saturation at both rails,
//     and the sample extremes,
//   - a long output stall while the sender keeps offering transactions, so
//     that the core fills its output register and stalls its input,
//   - three random phases with different idle patterns on the two channels.
module angle_correction_polynomial_core_test;
	import acp_pkg::*;

	// Slot of the highest grid term, coefficient * a^3 * x^3.
	localparam int TOP_TERM_IDX = (ORDER_POS + 1) * ORDER_ANGLE + ORDER_POS;

	// Width of the predictor's exact accumulator. The largest term is below
	// 2^154 in magnitude and 24 of them are summed, so 256 bits never wrap.
	localparam int ACC_BITS = 256;

	// The output stall must be long enough for a second evaluation to finish
	// behind the first result.
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int END_TAIL_CYCLES = 400;

	typedef logic signed [ACC_BITS-1:0] wide_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] angle;
		logic                      clipped;
	} angle_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic                             kind;
	logic [COEF_IDX_W-1:0]            coef_index;
	logic signed [COEF_W-1:0]         coef_value;
	logic signed [PORT_SAMPLE_W-1:0]  pos_x;
	logic signed [PORT_SAMPLE_W-1:0]  angle_a;
	logic signed [PORT_SAMPLE_W-1:0]  pos_y;
	logic                             out_valid;
	logic                             out_ready;
	logic signed [VALUE_W-1:0]        value;
	logic                             saturated;

	// Mirror of the core's coefficient table and the results still owed.
	logic signed [COEF_W-1:0] coef_mirror [TABLE_DEPTH];
	angle_result_t            expected_angles [$];

	// Idle rates in percent per cycle; the sender's is used by the main
	// process, the receiver's by the result process.
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	// Each increment asks the result process for one long output stall.
	int hold_token = 0;
	int err_count  = 0;

	angle_correction_polynomial_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.pos_x      (pos_x),
		.angle_a    (angle_a),
		.pos_y      (pos_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed limit; a correct run ends far earlier.
	initial begin
		#25_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Exact evaluation of the polynomial from the mirrored table, followed by
	// rounding half up to Q31.32 and saturation to the signed 64-bit range.
	function automatic angle_result_t corrected_angle(
		input logic signed [PORT_SAMPLE_W-1:0] xs,
		input logic signed [PORT_SAMPLE_W-1:0] ang,
		input logic signed [PORT_SAMPLE_W-1:0] ys);
		wide_t         pow_x [ORDER_POS+1];
		wide_t         pow_a [ORDER_ANGLE+1];
		wide_t         pow_y [3];
		wide_t         sum;
		wide_t         term;
		wide_t         half;
		wide_t         lim_hi;
		wide_t         lim_lo;
		int            b;
		angle_result_t r;

		pow_x[0] = 1;
		pow_a[0] = 1;
		pow_y[0] = 1;
		for (int k = 1; k <= ORDER_POS; k++) begin
			term = xs;
			pow_x[k] = pow_x[k-1] * term;
		end
		for (int k = 1; k <= ORDER_ANGLE; k++) begin
			term = ang;
			pow_a[k] = pow_a[k-1] * term;
		end
		for (int k = 1; k <= 2; k++) begin
			term = ys;
			pow_y[k] = pow_y[k-1] * term;
		end

		// Full a/x grid.
		sum = 0;
		for (int i = 0; i <= ORDER_ANGLE; i++) begin
			for (int j = 0; j <= ORDER_POS; j++) begin
				term = coef_mirror[(ORDER_POS + 1) * i + j];
				sum = sum + term * pow_a[i] * pow_x[j];
			end
		end

		// Cross terms for y and y^2: 1, x, a and a*x, in that order.
		for (int k = 1; k <= 2; k++) begin
			b = CROSS_BASE + 4 * (k - 1);
			term = coef_mirror[b];
			sum = sum + term * pow_y[k];
			term = coef_mirror[b + 1];
			sum = sum + term * pow_x[1] * pow_y[k];
			term = coef_mirror[b + 2];
			sum = sum + term * pow_a[1] * pow_y[k];
			term = coef_mirror[b + 3];
			sum = sum + term * pow_a[1] * pow_x[1] * pow_y[k];
		end

		// Adding half an output LSB before the floor sends ties toward plus
		// infinity.
		half = 1;
		half = half <<< (FRAC_DROP - 1);
		sum = (sum + half) >>> FRAC_DROP;

		lim_hi = {1'b0, {(VALUE_W-1){1'b1}}};
		lim_lo = -lim_hi - 1;
		if (sum > lim_hi) begin
			r.angle   = {1'b0, {(VALUE_W-1){1'b1}}};
			r.clipped = 1'b1;
		end else if (sum < lim_lo) begin
			r.angle   = {1'b1, {(VALUE_W-1){1'b0}}};
			r.clipped = 1'b1;
		end else begin
			r.angle   = sum[VALUE_W-1:0];
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	// Coefficients spread over many magnitudes, so that both clipped and
	// in-range results are common even with large samples.
	function automatic logic signed [COEF_W-1:0] rand_coef();
		logic signed [COEF_W-1:0] c;
		c = {$urandom, $urandom};
		if ($urandom_range(3) != 0)
			c = c >>> $urandom_range(COEF_W - 1);
		return c;
	endfunction

	function automatic logic signed [PORT_SAMPLE_W-1:0] rand_sample();
		logic signed [PORT_SAMPLE_W-1:0] s;
		s = PORT_SAMPLE_W'($urandom);
		if ($urandom_range(3) != 0)
			s = s >>> $urandom_range(PORT_SAMPLE_W - 1);
		return s;
	endfunction

	// Mostly valid slots, with an occasional index past the end of the table.
	function automatic logic [COEF_IDX_W-1:0] pick_index();
		if ($urandom_range(9) == 0)
			return COEF_IDX_W'($urandom_range((1 << COEF_IDX_W) - 1));
		return COEF_IDX_W'($urandom_range(TABLE_DEPTH - 1));
	endfunction

	// Offers one transaction after a random gap and returns once it has been
	// accepted. Valid stays high on return so that a following transaction
	// can go out back to back.
	task automatic send_item(
		input logic                            k,
		input logic [COEF_IDX_W-1:0]           idx,
		input logic signed [COEF_W-1:0]        cv,
		input logic signed [PORT_SAMPLE_W-1:0] xs,
		input logic signed [PORT_SAMPLE_W-1:0] ang,
		input logic signed [PORT_SAMPLE_W-1:0] ys);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		coef_index <= idx;
		coef_value <= cv;
		pos_x      <= xs;
		angle_a    <= ang;
		pos_y      <= ys;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);

		// A load past the table is dropped by the core and gives no result.
		if (k == KIND_LOAD) begin
			if (idx < TABLE_DEPTH)
				coef_mirror[idx] = cv;
		end else begin
			expected_angles.insert(expected_angles.size(), corrected_angle(xs, ang, ys));
		end
	endtask

	// The fields that a transaction does not use carry random junk.
	task automatic load_coef(input logic [COEF_IDX_W-1:0] idx,
		input logic signed [COEF_W-1:0] cv);
		send_item(KIND_LOAD, idx, cv, rand_sample(), rand_sample(), rand_sample());
	endtask

	task automatic eval_point(input logic signed [PORT_SAMPLE_W-1:0] xs,
		input logic signed [PORT_SAMPLE_W-1:0] ang,
		input logic signed [PORT_SAMPLE_W-1:0] ys);
		send_item(KIND_EVAL, pick_index(), rand_coef(), xs, ang, ys);
	endtask

	// Drops valid and waits until every owed result has arrived.
	task automatic finish_stream();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_angles.size() != 0)
			@(posedge clk);
	endtask

	// Every slot gets a value before the first evaluation reads the table.
	task automatic test_table_fill();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (int slot = 0; slot < TABLE_DEPTH; slot++)
			load_coef(COEF_IDX_W'(slot), rand_coef());
		finish_stream();
	endtask

	// With all three samples zero only the constant coefficient survives, so
	// its rounding can be observed directly.
	task automatic test_directed_corners();
		logic signed [COEF_W-1:0] coef_max;
		logic signed [COEF_W-1:0] coef_min;
		logic signed [COEF_W-1:0] tie;

		coef_max = {1'b0, {(COEF_W-1){1'b1}}};
		coef_min = {1'b1, {(COEF_W-1){1'b0}}};
		tie      = 1;
		tie      = tie <<< (FRAC_DROP - 1);
		src_idle_pct  = 0;
		sink_idle_pct = 0;

		// Loads past the table must leave every slot as it was.
		load_coef(COEF_IDX_W'(TABLE_DEPTH), coef_max);
		load_coef(COEF_IDX_W'((1 << COEF_IDX_W) - 1), coef_min);
		eval_point(16'sd1, -16'sd1, 16'sd1);

		// Exact ties round up on both sides of zero.
		load_coef(0, tie);
		eval_point(0, 0, 0);
		load_coef(0, -tie);
		eval_point(0, 0, 0);

		// Coefficient extremes stay inside the output range.
		load_coef(0, coef_max);
		eval_point(0, 0, 0);
		load_coef(0, coef_min);
		eval_point(0, 0, 0);

		// The a^3*x^3 term at full scale dwarfs all others and clips.
		load_coef(COEF_IDX_W'(TOP_TERM_IDX), coef_max);
		eval_point(-16'sd32768, -16'sd32768, 0);
		load_coef(COEF_IDX_W'(TOP_TERM_IDX), coef_min);
		eval_point(-16'sd32768, -16'sd32768, 0);

		// Sample extremes, including the y^2 group.
		eval_point(16'sd32767, 16'sd32767, 16'sd32767);
		eval_point(-16'sd32768, -16'sd32768, -16'sd32768);
		eval_point(16'sd32767, -16'sd32768, -16'sd32768);
		eval_point(0, 0, 16'sd32767);
		finish_stream();
	endtask

	// The receiver holds off long enough for the output register to fill and
	// a second evaluation to finish behind it, so the input has to stall.
	task automatic test_output_backpressure();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_token++;
		for (int n = 0; n < 5; n++)
			eval_point(rand_sample(), rand_sample(), rand_sample());
		load_coef(pick_index(), rand_coef());
		eval_point(rand_sample(), rand_sample(), rand_sample());
		finish_stream();
	endtask

	task automatic test_random_traffic(input int n_items, input int src_pct,
		input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(99) < 35)
				load_coef(pick_index(), rand_coef());
			else
				eval_point(rand_sample(), rand_sample(), rand_sample());
		end
		finish_stream();
	endtask

	// Result process: checks every accepted result against the oldest owed
	// one, then chooses the next cycle's ready, honoring a requested stall.
	initial begin : result_sink
		int            hold_seen;
		int            hold_left;
		angle_result_t want;

		hold_seen = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_angles.size() == 0) begin
					$error("result with no evaluation pending: value=%h saturated=%b",
						value, saturated);
					err_count++;
				end else begin
					want = expected_angles.pop_front();
					if (value !== want.angle) begin
						$error("value mismatch: expected %h, actual %h", want.angle, value);
						err_count++;
					end
					if (saturated !== want.clipped) begin
						$error("saturated mismatch: expected %b, actual %b",
							want.clipped, saturated);
						err_count++;
					end
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		kind       <= KIND_EVAL;
		coef_index <= '0;
		coef_value <= '0;
		pos_x      <= '0;
		angle_a    <= '0;
		pos_y      <= '0;
		for (int slot = 0; slot < TABLE_DEPTH; slot++)
			coef_mirror[slot] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_directed_corners();
		test_output_backpressure();
		// Sender idles in a third of the cycles, receiver in most of them,
		// then the other way round, then both run flat out.
		test_random_traffic(640, 33, 77);
		test_random_traffic(640, 77, 33);
		test_random_traffic(640, 0, 0);

		// Any result that shows up in the tail is unexpected and fails.
		repeat (END_TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/acp_pkg.sv
rtl/acp_ram.sv
rtl/acp_datapath.sv
rtl/acp_seq.sv
rtl/angle_correction_polynomial_core.sv
sim/angle_correction_polynomial_core_test.sv
